/* design/wva_pkg.sv */
// ----------------------------------------------------------------------------
// wva_pkg
// Shared types and constants for the windowed vector averager.
// ----------------------------------------------------------------------------
package wva_pkg;

	localparam int unsigned CAPACITY = 16;
	localparam int unsigned IDX_W    = $clog2(CAPACITY);
	localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
	localparam int unsigned SMP_W    = 32;
	localparam int unsigned AGE_W    = 24;
	localparam int unsigned EL_W     = 20;
	localparam int unsigned SUM_W    = SMP_W + CNT_W;

	// register indexes
	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_LIMIT  = 2'd1;
	localparam logic [1:0] REG_WINDOW = 2'd2;

	// smoothing modes
	localparam logic [1:0] MODE_PLAIN = 2'd0;
	localparam logic [1:0] MODE_TIME  = 2'd1;
	localparam logic [1:0] MODE_COUNT = 2'd2;

	localparam logic [1:0]  MODE_RST   = MODE_PLAIN;
	localparam logic [23:0] LIMIT_RST  = 24'd100000;
	localparam logic [7:0]  WINDOW_RST = 8'd3;

	typedef struct packed {
		logic signed [SMP_W-1:0] x;
		logic signed [SMP_W-1:0] y;
		logic signed [SMP_W-1:0] z;
		logic [EL_W-1:0]         elapsed;
	} item_t;

	typedef struct packed {
		logic [1:0]       mode;
		logic [AGE_W-1:0] limit;
		logic [7:0]       window;
	} cfg_t;

endpackage

/* design/wva_front.sv */
// ----------------------------------------------------------------------------
// wva_front
// Input side: accepts items into a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module wva_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  wva_pkg::item_t in_item,
	output logic           q_valid,
	output wva_pkg::item_t q_item,
	input  logic           q_pop
);

	wva_pkg::item_t buf_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	logic           pop;

	assign in_ready = (count_q != 2'd2);
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = buf_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && q_valid;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= in_item;
		end
	end

	// queue pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

/* design/wva_back.sv */
// ----------------------------------------------------------------------------
// wva_back
// Sequencer: ages and purges the sample store in time mode, trims the
// window, inserts the sample, sums, divides serially and holds the result.
// ----------------------------------------------------------------------------
module wva_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  wva_pkg::cfg_t                cfg,
	input  logic                         q_valid,
	input  wva_pkg::item_t               q_item,
	output logic                         q_pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [31:0]           mean_x,
	output logic signed [31:0]           mean_y,
	output logic signed [31:0]           mean_z,
	output logic [4:0]                   used_count
);

	localparam int unsigned IW = wva_pkg::IDX_W;
	localparam int unsigned CW = wva_pkg::CNT_W;
	localparam int unsigned SW = wva_pkg::SUM_W;
	localparam int unsigned AW = wva_pkg::AGE_W;
	localparam int unsigned DCW = $clog2(SW + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_AGE  = 3'd1;
	localparam logic [2:0] S_FIT  = 3'd2;
	localparam logic [2:0] S_WR   = 3'd3;
	localparam logic [2:0] S_SUM  = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	// sample store
	logic signed [31:0] st_x_q [wva_pkg::CAPACITY];
	logic signed [31:0] st_y_q [wva_pkg::CAPACITY];
	logic signed [31:0] st_z_q [wva_pkg::CAPACITY];
	logic [AW-1:0]      st_age_q [wva_pkg::CAPACITY];

	logic [2:0]         state_q;
	wva_pkg::item_t     item_q;
	logic [CW-1:0]      fill_q;
	logic [IW-1:0]      oldest_q;
	logic [CW-1:0]      k_q;
	logic [CW-1:0]      purge_q;
	logic signed [SW-1:0] sum_q [3];
	logic [SW-1:0]      mag_q [3];
	logic [CW-1:0]      rem_q [3];
	logic               neg_q [3];
	logic [DCW-1:0]     dcnt_q;
	logic               out_valid_q;
	logic signed [31:0] mean_q [3];

	logic [IW-1:0]      slot;
	logic [AW:0]        age_sum;
	logic [AW-1:0]      age_new;
	logic               age_wr;
	logic [8:0]         win;
	logic [CW-1:0]      win_c;
	logic [CW-1:0]      drop_n;
	logic               st_wr;
	logic [IW-1:0]      wr_slot;
	logic [CW:0]        trial [3];
	logic               load_out;
	logic signed [SW-1:0] q_signed [3];

	assign slot    = oldest_q + k_q[IW-1:0];
	assign age_sum = {1'b0, st_age_q[slot]} + (AW+1)'(item_q.elapsed);
	assign age_new = age_sum[AW] ? {AW{1'b1}} : age_sum[AW-1:0];
	assign age_wr  = (state_q == S_AGE) && (k_q != fill_q);
	assign st_wr   = (state_q == S_WR);
	assign wr_slot = oldest_q + fill_q[IW-1:0];
	assign q_pop   = (state_q == S_IDLE) && q_valid;
	assign load_out = (state_q == S_OUT) && (!out_valid_q || out_ready);

	// window size for the current mode
	always_comb begin
		win = 9'd2;
		case (cfg.mode)
			wva_pkg::MODE_TIME: begin
				win = 9'(wva_pkg::CAPACITY);
			end
			wva_pkg::MODE_COUNT: begin
				win = {1'b0, cfg.window} + 9'd1;
				if (win < 9'd2) begin
					win = 9'd2;
				end
				if (win > 9'(wva_pkg::CAPACITY)) begin
					win = 9'(wva_pkg::CAPACITY);
				end
			end
			default: begin
				win = 9'd2;
			end
		endcase
		win_c  = win[CW-1:0];
		drop_n = fill_q - win_c + CW'(1);
	end

	// one restoring division step per axis
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			trial[i]    = {rem_q[i], mag_q[i][SW-1]};
			q_signed[i] = neg_q[i] ? -$signed(mag_q[i]) : $signed(mag_q[i]);
		end
	end

	// store writes
	always_ff @(posedge clk) begin
		if (age_wr) begin
			st_age_q[slot] <= age_new;
		end
		if (st_wr) begin
			st_x_q[wr_slot]   <= item_q.x;
			st_y_q[wr_slot]   <= item_q.y;
			st_z_q[wr_slot]   <= item_q.z;
			st_age_q[wr_slot] <= '0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		case (state_q)
			S_WR: begin
				for (int i = 0; i < 3; i++) begin
					sum_q[i] <= '0;
				end
			end
			S_SUM: begin
				if (k_q != fill_q) begin
					sum_q[0] <= sum_q[0] + SW'(st_x_q[slot]);
					sum_q[1] <= sum_q[1] + SW'(st_y_q[slot]);
					sum_q[2] <= sum_q[2] + SW'(st_z_q[slot]);
				end else begin
					for (int i = 0; i < 3; i++) begin
						neg_q[i] <= sum_q[i][SW-1];
						mag_q[i] <= sum_q[i][SW-1] ? SW'(-sum_q[i]) : SW'(sum_q[i]);
						rem_q[i] <= '0;
					end
				end
			end
			S_DIV: begin
				if (dcnt_q != DCW'(SW)) begin
					for (int i = 0; i < 3; i++) begin
						if (trial[i] >= {1'b0, fill_q}) begin
							rem_q[i] <= CW'(trial[i] - {1'b0, fill_q});
							mag_q[i] <= {mag_q[i][SW-2:0], 1'b1};
						end else begin
							rem_q[i] <= trial[i][CW-1:0];
							mag_q[i] <= {mag_q[i][SW-2:0], 1'b0};
						end
					end
				end
			end
			default: begin
			end
		endcase
		if (load_out) begin
			for (int i = 0; i < 3; i++) begin
				mean_q[i] <= q_signed[i][31:0];
			end
			used_count <= 5'(fill_q);
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			oldest_q    <= '0;
			k_q         <= '0;
			purge_q     <= '0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !load_out) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						k_q     <= '0;
						purge_q <= '0;
						state_q <= (cfg.mode == wva_pkg::MODE_TIME) ? S_AGE : S_FIT;
					end
				end
				S_AGE: begin
					if (k_q != fill_q) begin
						k_q <= k_q + CW'(1);
						if (age_new >= cfg.limit) begin
							purge_q <= purge_q + CW'(1);
						end
					end else begin
						fill_q   <= fill_q - purge_q;
						oldest_q <= oldest_q + purge_q[IW-1:0];
						state_q  <= S_FIT;
					end
				end
				S_FIT: begin
					if (fill_q >= win_c) begin
						oldest_q <= oldest_q + drop_n[IW-1:0];
						fill_q   <= win_c - CW'(1);
					end
					state_q <= S_WR;
				end
				S_WR: begin
					fill_q  <= fill_q + CW'(1);
					k_q     <= '0;
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (k_q != fill_q) begin
						k_q <= k_q + CW'(1);
					end else begin
						dcnt_q  <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (dcnt_q != DCW'(SW)) begin
						dcnt_q <= dcnt_q + DCW'(1);
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign mean_x    = mean_q[0];
	assign mean_y    = mean_q[1];
	assign mean_z    = mean_q[2];

endmodule

/* design/windowed_vector_averager.sv */
// ----------------------------------------------------------------------------
// windowed_vector_averager
// Moving average of three-axis samples over a plain, time or count window.
// ----------------------------------------------------------------------------
// Input items (sample_x/y/z, elapsed_us) arrive on in_valid/in_ready and land
// in a two-entry queue, so the sender is held off only when that queue fills.
// Each item gives one result (mean_x/y/z, used_count) on out_valid/out_ready.
// The back end handles one item at a time: it takes the item, in time mode
// walks the ages of the samples already stored, trims the window and
// inserts the item, sums the samples kept (their number is used_count, at
// most 16), divides bit-serially by the count and loads the output register.
// Most of the time per item goes to the store walk and the serial divider.
// A result waits in the output register while out_ready is low; the back end
// goes on with the next item and stalls only when its next result is ready to
// load while the old one still waits, and the input queue keeps taking items
// until it is full. Reset empties the window and the queue and sets the
// registers to plain mode, age limit 100000 us and window setting 3. Registers
// sit at byte addresses 0 (mode), 4 (age limit) and 8 (window setting).
// ----------------------------------------------------------------------------
module windowed_vector_averager (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] sample_x,
	input  logic signed [31:0] sample_y,
	input  logic signed [31:0] sample_z,
	input  logic [19:0]        elapsed_us,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] mean_x,
	output logic signed [31:0] mean_y,
	output logic signed [31:0] mean_z,
	output logic [4:0]         used_count
);

	wva_pkg::cfg_t  cfg_q;
	wva_pkg::item_t in_item;
	wva_pkg::item_t q_item;
	logic           q_valid;
	logic           q_pop;
	logic           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode   <= wva_pkg::MODE_RST;
			cfg_q.limit  <= wva_pkg::LIMIT_RST;
			cfg_q.window <= wva_pkg::WINDOW_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				wva_pkg::REG_MODE:   cfg_q.mode   <= pwdata[1:0];
				wva_pkg::REG_LIMIT:  cfg_q.limit  <= pwdata[23:0];
				wva_pkg::REG_WINDOW: cfg_q.window <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// register read back
	always_comb begin
		case (paddr[3:2])
			wva_pkg::REG_MODE:   prdata = {30'd0, cfg_q.mode};
			wva_pkg::REG_LIMIT:  prdata = {8'd0, cfg_q.limit};
			wva_pkg::REG_WINDOW: prdata = {24'd0, cfg_q.window};
			default:             prdata = 32'd0;
		endcase
	end

	assign in_item.x       = sample_x;
	assign in_item.y       = sample_y;
	assign in_item.z       = sample_z;
	assign in_item.elapsed = elapsed_us;

	wva_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	wva_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.mean_x     (mean_x),
		.mean_y     (mean_y),
		.mean_z     (mean_z),
		.used_count (used_count)
	);

endmodule

/* tb/sv/tb_windowed_vector_averager.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_windowed_vector_averager
// Self-checking regression of the windowed vector averager: a predictor keeps
// its own sample window and computes each mean; results are compared in order
// while both channels idle at random and the registers step through settings.
// ----------------------------------------------------------------------------
module tb_windowed_vector_averager;

	localparam int unsigned WDOG_LIMIT = 20000;

	typedef struct packed {
		logic signed [31:0] mx;
		logic signed [31:0] my;
		logic signed [31:0] mz;
		logic [4:0]         cnt;
	} mean_t;

	// window predictor and queue of expected means
	class mean_scoreboard;
		logic signed [31:0] win_x[wva_pkg::CAPACITY];
		logic signed [31:0] win_y[wva_pkg::CAPACITY];
		logic signed [31:0] win_z[wva_pkg::CAPACITY];
		logic [23:0]        win_age[wva_pkg::CAPACITY];
		int unsigned        fill;
		int unsigned        head;
		logic [1:0]         mode;
		logic [23:0]        limit;
		logic [7:0]         wset;
		mean_t              pending[$];
		int unsigned        errors;
		int unsigned        checked;

		function new();
			fill = 0; head = 0; errors = 0; checked = 0;
			mode = wva_pkg::MODE_RST; limit = wva_pkg::LIMIT_RST;
			wset = wva_pkg::WINDOW_RST;
		endfunction

		function void note_item(wva_pkg::item_t it);
			int unsigned win, purge, s, k;
			logic [24:0] a;
			longint sx, sy, sz;
			mean_t m;
			win = 2;
			if (mode == wva_pkg::MODE_TIME) begin
				purge = 0;
				for (k = 0; k < fill; k++) begin
					s = (head + k) % wva_pkg::CAPACITY;
					a = win_age[s] + it.elapsed;
					if (a > 25'hFFFFFF) a = 25'hFFFFFF;
					win_age[s] = a[23:0];
					if (a[23:0] >= limit) purge++;
				end
				head = (head + purge) % wva_pkg::CAPACITY;
				fill -= purge;
				win = wva_pkg::CAPACITY;
			end else if (mode == wva_pkg::MODE_COUNT) begin
				win = wset + 1;
				if (win < 2) win = 2;
				if (win > wva_pkg::CAPACITY) win = wva_pkg::CAPACITY;
			end
			while (fill >= win) begin
				head = (head + 1) % wva_pkg::CAPACITY;
				fill--;
			end
			s = (head + fill) % wva_pkg::CAPACITY;
			win_x[s] = it.x; win_y[s] = it.y; win_z[s] = it.z; win_age[s] = 0;
			fill++;
			sx = 0; sy = 0; sz = 0;
			for (k = 0; k < fill; k++) begin
				s = (head + k) % wva_pkg::CAPACITY;
				sx += win_x[s]; sy += win_y[s]; sz += win_z[s];
			end
			m.mx = 32'(sx / longint'(fill));
			m.my = 32'(sy / longint'(fill));
			m.mz = 32'(sz / longint'(fill));
			m.cnt = fill[4:0];
			pending.push_back(m);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			if (errors <= 30)
				$display("mismatch %s: got %h want %h (result %0d)", what, got, want, checked);
		endtask

		task check_mean(mean_t got);
			mean_t w;
			if (pending.size() == 0) begin
				report("unexpected result", got.mx, 0);
				return;
			end
			w = pending.pop_front();
			if (got.mx !== w.mx) report("mean_x", got.mx, w.mx);
			if (got.my !== w.my) report("mean_y", got.my, w.my);
			if (got.mz !== w.mz) report("mean_z", got.mz, w.mz);
			if (got.cnt !== w.cnt) report("used_count", 32'(got.cnt), 32'(w.cnt));
			checked++;
		endtask
	endclass

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = 0;
	logic [31:0] pwdata = 0, prdata;
	logic pready;
	logic in_valid = 0, in_ready, out_valid, out_ready = 0;
	logic signed [31:0] sample_x = 0, sample_y = 0, sample_z = 0;
	logic [19:0] elapsed_us = 0;
	logic signed [31:0] mean_x, mean_y, mean_z;
	logic [4:0] used_count;

	mean_scoreboard sb = new();
	bit calm = 0;
	int unsigned idle_cycles = 0;
	int unsigned sent = 0;

	windowed_vector_averager i_dut (.*);

	always #5 clk = ~clk;

	// result side: random stalls, check on acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_mean('{mean_x, mean_y, mean_z, used_count});
			out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 34);
		end
	end

	// watchdog on cycles with no accepted item
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("watchdog expired");
			$display("windowed_vector_averager regression: fail");
			$finish;
		end
	end

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			wva_pkg::REG_MODE:   sb.mode = val[1:0];
			wva_pkg::REG_LIMIT:  sb.limit = val[23:0];
			wva_pkg::REG_WINDOW: sb.wset = val[7:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_item(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [19:0] el);
		wva_pkg::item_t it;
		// random idle cycles drop valid between items
		while (!calm && $urandom_range(99) < 34) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1; sample_x <= x; sample_y <= y; sample_z <= z; elapsed_us <= el;
		it = '{x, y, z, el};
		do @(posedge clk); while (!in_ready);
		sb.note_item(it);
		sent++;
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic logic [31:0] rnd_sample();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(4096) - 2048;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [19:0] rnd_elapsed(logic [23:0] lim);
		case ($urandom_range(5))
			0: return 20'hFFFFF;
			1: return 0;
			2: return 20'($urandom_range(lim > 20'hFFFFF ? 20'hFFFFF : lim));
			default: return 20'($urandom);
		endcase
	endfunction

	initial begin
		int unsigned ph, k;
		logic [23:0] lim;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: reset setting, field extremes, unused selector, zero limit
		send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 20'h0);
		send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 20'hFFFFF);
		send_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 20'h0);
		drain();
		reg_write(wva_pkg::REG_MODE, wva_pkg::MODE_COUNT);
		reg_write(wva_pkg::REG_WINDOW, 8'd255);
		for (k = 0; k < 18; k++) send_item(32'h7FFF_FFFF, 32'h8000_0000, -k, 20'h0);
		drain();
		reg_write(wva_pkg::REG_WINDOW, 8'd0);
		send_item(32'd3, -32'sd3, 32'd5, 20'd1);
		send_item(32'd0, 32'd0, 32'd0, 20'd1);
		drain();
		reg_write(wva_pkg::REG_MODE, 2'd3);
		send_item(32'd7, 32'd7, 32'd7, 20'd0);
		drain();
		reg_write(wva_pkg::REG_MODE, wva_pkg::MODE_TIME);
		reg_write(wva_pkg::REG_LIMIT, 24'd0);
		send_item(32'd1, 32'd1, 32'd1, 20'd0);
		send_item(32'd2, 32'd2, 32'd2, 20'd0);
		drain();
		// random phases
		for (ph = 0; ph < 13; ph++) begin
			calm = (ph == 6);
			reg_write(wva_pkg::REG_MODE, ph % 4 == 3 ? $urandom_range(3) : ph % 3);
			case ($urandom_range(3))
				0: lim = 24'hFFFFFF;
				1: lim = 24'($urandom_range(3000));
				default: lim = 24'($urandom);
			endcase
			if (ph == 4) lim = 0;
			reg_write(wva_pkg::REG_LIMIT, lim);
			reg_write(wva_pkg::REG_WINDOW,
					ph == 2 ? 8'd255 : (ph == 5 ? 8'd1 : $urandom_range(20)));
			for (k = 0; k < 100; k++) begin
				if (ph % 2) send_item(rnd_sample(), rnd_sample(), rnd_sample(),
						20'($urandom_range(lim / 4 > 1000 ? 1000 : lim / 4 + 1)));
				else send_item(rnd_sample(), rnd_sample(), rnd_sample(), rnd_elapsed(lim));
			end
			drain();
		end
		calm = 0;
		$display("covered %0d items over plain, time, count and unused modes", sent);
		$display("checked %0d results, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("windowed_vector_averager regression: pass");
		else
			$display("windowed_vector_averager regression: fail");
		$finish;
	end

endmodule

/* filelist.f */
design/wva_pkg.sv
design/wva_front.sv
design/wva_back.sv
design/windowed_vector_averager.sv
tb/sv/tb_windowed_vector_averager.sv
